/* rtl/pal_pkg.sv */
`timescale 1ns / 1ps

package pal_pkg;

   // Storage geometry
   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   // Fixed word field widths
   localparam int OP_W    = 3;
   localparam int POS_W   = 6;
   localparam int VALUE_W = 32;
   localparam int FIDX_W  = 6;
   localparam int COUNT_W = 7;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
   localparam logic [OP_W-1:0] OP_GET    = 3'd2;
   localparam logic [OP_W-1:0] OP_SET    = 3'd3;
   localparam logic [OP_W-1:0] OP_LOCATE = 3'd4;

   // Command broadcast to every cell, flags set only for accepted operations
   typedef struct packed {
      logic                  go;     // a word was taken this cycle
      logic                  ins;
      logic                  del;
      logic                  wr;
      logic                  rd;
      logic                  loc;
      logic [IDX_W-1:0]      pos;
      logic [DATA_WIDTH-1:0] data;
      logic [CNT_W-1:0]      count;
   } cmd_type;

endpackage

/* rtl/pal_if.sv */
`timescale 1ns / 1ps

// Request word channel
interface pal_req_if;
   logic                               valid;
   logic                               ready;
   logic        [pal_pkg::OP_W-1:0]    operation;
   logic        [pal_pkg::POS_W-1:0]   position;
   logic signed [pal_pkg::VALUE_W-1:0] value;

   modport source (output valid, output operation, output position, output value,
                   input ready);
   modport sink   (input valid, input operation, input position, input value,
                   output ready);
endinterface

// Response word channel
interface pal_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               ok;
   logic signed [pal_pkg::VALUE_W-1:0] read_value;
   logic                               found;
   logic        [pal_pkg::FIDX_W-1:0]  found_index;
   logic        [pal_pkg::COUNT_W-1:0] count;
   logic                               full_res;
   logic                               empty_res;

   modport source (output valid, output ok, output read_value, output found,
                   output found_index, output count, output full_res,
                   output empty_res, input ready);
   modport sink   (input valid, input ok, input read_value, input found,
                   input found_index, input count, input full_res,
                   input empty_res, output ready);
endinterface

/* rtl/pal_cell.sv */
`timescale 1ns / 1ps

// One list slot: shifts from a neighbor, takes a write, compares for locate.
module pal_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [pal_pkg::IDX_W-1:0]          cell_idx,
   input  pal_pkg::cmd_type                   cmd,
   input  logic [pal_pkg::DATA_WIDTH-1:0]     prev_entry,
   input  logic [pal_pkg::DATA_WIDTH-1:0]     next_entry,
   output logic [pal_pkg::DATA_WIDTH-1:0]     entry,
   output logic                               hit,
   output logic                               rd_hit,
   output logic [pal_pkg::DATA_WIDTH-1:0]     rdata
);

   logic [pal_pkg::DATA_WIDTH-1:0] entry_ff, entry_in;
   logic                           hit_ff, hit_in;
   logic                           rd_hit_ff, rd_hit_in;
   logic [pal_pkg::DATA_WIDTH-1:0] rdata_ff, rdata_in;
   logic                           at_pos, above_pos, occupied;

   assign at_pos    = (cell_idx == cmd.pos);
   assign above_pos = (cell_idx > cmd.pos);
   assign occupied  = (pal_pkg::CNT_W'(cell_idx) < cmd.count);

   // Entry update: insert pulls from below, delete pulls from above
   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins && above_pos) begin
         entry_in = prev_entry;
      end else if ((cmd.ins || cmd.wr) && at_pos) begin
         entry_in = cmd.data;
      end else if (cmd.del && (above_pos || at_pos)) begin
         entry_in = next_entry;
      end
   end

   // Per-cell read select and locate match, against the old contents
   always_comb begin
      rd_hit_in = cmd.rd && at_pos;
      hit_in    = cmd.loc && occupied && (entry_ff == cmd.data);
      rdata_in  = rd_hit_in ? entry_ff : '0;
   end

   // Read and match flags are held from acceptance until the next word
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (cmd.go) begin
         rdata_ff <= rdata_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff    <= 1'b0;
         rd_hit_ff <= 1'b0;
      end else if (cmd.go) begin
         hit_ff    <= hit_in;
         rd_hit_ff <= rd_hit_in;
      end
   end

   assign entry  = entry_ff;
   assign hit    = hit_ff;
   assign rd_hit = rd_hit_ff;
   assign rdata  = rdata_ff;

endmodule

/* rtl/positional_array_list_core.sv */
`timescale 1ns / 1ps

// Channel   Dir  Word
// req_ch    in   operation, position, value
// rsp_ch    out  ok, read_value, found, found_index, count, full_res, empty_res
//
// Each word runs through the idle and reduce states: the cell row shifts or writes and registers its
// compare/read flags at acceptance, then the reduce state reduces them into the output
// register. A new request is taken only once the previous word has been loaded there.
// Reset clears the count and control; list contents stay undefined until written.
// A stalled response holds the reduce cycle until the output register frees up.
module positional_array_list_core (
   input  logic      clock,
   input  logic      reset,
   pal_req_if.sink   req_ch,
   pal_rsp_if.source rsp_ch
);

   typedef enum logic [1:0] {
      S_IDLE   = 2'b01,
      S_REDUCE = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [pal_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      ok_ff, ok_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_ok_ff;
   logic [pal_pkg::VALUE_W-1:0] rsp_rd_ff;
   logic                      rsp_found_ff;
   logic [pal_pkg::FIDX_W-1:0] rsp_fidx_ff;
   logic [pal_pkg::COUNT_W-1:0] rsp_count_ff;
   logic                      rsp_full_ff, rsp_empty_ff;

   logic                      accept, load;
   logic [pal_pkg::CNT_W-1:0] pos_c;
   logic                      ins_ok, del_ok, get_ok, set_ok, loc_op;
   pal_pkg::cmd_type          cmd;

   logic [pal_pkg::DATA_WIDTH-1:0] entry [pal_pkg::CAPACITY];
   logic [pal_pkg::DATA_WIDTH-1:0] rdata [pal_pkg::CAPACITY];
   logic [pal_pkg::CAPACITY-1:0]   hit;
   logic [pal_pkg::CAPACITY-1:0]   rd_hit;

   logic [pal_pkg::DATA_WIDTH-1:0] rd_or;
   logic [pal_pkg::IDX_W-1:0]      first_idx;
   logic                           any_hit;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   // Operation checks against the current count
   always_comb begin
      pos_c  = pal_pkg::CNT_W'(req_ch.position);
      ins_ok = (req_ch.operation == pal_pkg::OP_INSERT) && (pos_c <= count_ff) &&
               (count_ff < pal_pkg::CNT_W'(pal_pkg::CAPACITY));
      del_ok = (req_ch.operation == pal_pkg::OP_DELETE) && (pos_c < count_ff);
      get_ok = (req_ch.operation == pal_pkg::OP_GET) && (pos_c < count_ff);
      set_ok = (req_ch.operation == pal_pkg::OP_SET) && (pos_c < count_ff);
      loc_op = (req_ch.operation == pal_pkg::OP_LOCATE);
   end

   always_comb begin
      cmd.go    = accept;
      cmd.ins   = accept && ins_ok;
      cmd.del   = accept && del_ok;
      cmd.wr    = accept && set_ok;
      cmd.rd    = accept && get_ok;
      cmd.loc   = accept && loc_op;
      cmd.pos   = pal_pkg::IDX_W'(req_ch.position);
      cmd.data  = pal_pkg::DATA_WIDTH'(req_ch.value);
      cmd.count = count_ff;
   end

   // Cell row
   for (genvar i = 0; i < pal_pkg::CAPACITY; i++) begin : g_cell
      logic [pal_pkg::DATA_WIDTH-1:0] prev_e, next_e;
      if (i == 0) begin : g_first
         assign prev_e = entry[i];
      end else begin : g_prev
         assign prev_e = entry[i-1];
      end
      if (i == pal_pkg::CAPACITY - 1) begin : g_last
         assign next_e = entry[i];
      end else begin : g_next
         assign next_e = entry[i+1];
      end
      pal_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (pal_pkg::IDX_W'(i)),
         .cmd        (cmd),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .entry      (entry[i]),
         .hit        (hit[i]),
         .rd_hit     (rd_hit[i]),
         .rdata      (rdata[i])
      );
   end

   // Reduce: OR of gated read data, lowest matching index
   always_comb begin
      rd_or     = '0;
      first_idx = '0;
      for (int k = 0; k < pal_pkg::CAPACITY; k++) begin
         rd_or = rd_or | rdata[k];
      end
      for (int k = pal_pkg::CAPACITY - 1; k >= 0; k--) begin
         if (hit[k]) begin
            first_idx = pal_pkg::IDX_W'(k);
         end
      end
      any_hit = |hit;
   end

   assign load = (state_ff == S_REDUCE) && (!rsp_valid_ff || rsp_ch.ready);

   // Control
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ok_in    = ins_ok || del_ok || get_ok || set_ok || loc_op;
               state_in = S_REDUCE;
               if (ins_ok) begin
                  count_in = count_ff + pal_pkg::CNT_W'(1);
               end else if (del_ok) begin
                  count_in = count_ff - pal_pkg::CNT_W'(1);
               end
            end
         end
         S_REDUCE: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ok_ff    <= ok_ff;
         rsp_rd_ff    <= pal_pkg::VALUE_W'(rd_or);
         rsp_found_ff <= any_hit;
         rsp_fidx_ff  <= pal_pkg::FIDX_W'(first_idx);
         rsp_count_ff <= pal_pkg::COUNT_W'(count_ff);
         rsp_full_ff  <= (count_ff == pal_pkg::CNT_W'(pal_pkg::CAPACITY));
         rsp_empty_ff <= (count_ff == '0);
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.ok          = rsp_ok_ff;
   assign rsp_ch.read_value  = rsp_rd_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.found_index = rsp_fidx_ff;
   assign rsp_ch.count       = rsp_count_ff;
   assign rsp_ch.full_res    = rsp_full_ff;
   assign rsp_ch.empty_res   = rsp_empty_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pal_pkg::CNT_W'(pal_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_single_read: assert property (@(posedge clock) disable iff (reset)
      $onehot0(rd_hit))
      else $error("more than one cell selected for read");

   a_accept_reduce: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_REDUCE))
      else $error("accepted word not followed by reduce cycle");

   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_full_ff && rsp_empty_ff))
      else $error("response both full and empty");

   a_no_read_on_locate: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REDUCE && any_hit) |-> (rd_hit == '0))
      else $error("read and locate flags both set");
`endif

endmodule

/* tb/positional_array_list_core_tb.sv */
`timescale 1ns / 1ps

module positional_array_list_core_tb;

   // Codes the block has to reject
   localparam logic [pal_pkg::OP_W-1:0] OP_RSVD5 = 3'd5;
   localparam logic [pal_pkg::OP_W-1:0] OP_RSVD6 = 3'd6;
   localparam logic [pal_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

   localparam logic signed [pal_pkg::VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [pal_pkg::VALUE_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

   localparam int LIMIT_CYCLES     = 600000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES      = 10;

   // One expected response word
   typedef struct packed {
      logic                              ok;
      logic signed [pal_pkg::VALUE_W-1:0] read_value;
      logic                              found;
      logic [pal_pkg::FIDX_W-1:0]        found_index;
      logic [pal_pkg::COUNT_W-1:0]       count;
      logic                              full_res;
      logic                              empty_res;
   } list_result_type;

   logic clock;
   logic reset;

   pal_req_if req_ch ();
   pal_rsp_if rsp_ch ();

   positional_array_list_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow copy of the list
   logic signed [pal_pkg::VALUE_W-1:0] list_words [pal_pkg::CAPACITY];
   int                                 list_len = 0;

   list_result_type pending_results [$];
   list_result_type exp_res;
   int              failures      = 0;
   int              cycle_count   = 0;
   bit              no_idle       = 1'b0;
   int              hold_requests = 0;
   int              holds_served  = 0;

   logic [pal_pkg::OP_W-1:0] reserved_ops [3] = '{OP_RSVD5, OP_RSVD6, OP_RSVD7};

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Applies one operation to the shadow list and returns its response word
   function automatic list_result_type predict_list_op(
         input logic [pal_pkg::OP_W-1:0] op,
         input logic [pal_pkg::POS_W-1:0] pos,
         input logic signed [pal_pkg::VALUE_W-1:0] val);
      list_result_type r;
      int              k;
      r = '0;
      case (op)
         pal_pkg::OP_INSERT: begin
            if (pos <= list_len && list_len < pal_pkg::CAPACITY) begin
               for (k = list_len; k > pos; k--) list_words[k] = list_words[k-1];
               list_words[pos] = val;
               list_len++;
               r.ok = 1'b1;
            end
         end
         pal_pkg::OP_DELETE: begin
            if (pos < list_len) begin
               for (k = pos; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
               list_len--;
               r.ok = 1'b1;
            end
         end
         pal_pkg::OP_GET: begin
            if (pos < list_len) begin
               r.read_value = list_words[pos];
               r.ok = 1'b1;
            end
         end
         pal_pkg::OP_SET: begin
            if (pos < list_len) begin
               list_words[pos] = val;
               r.ok = 1'b1;
            end
         end
         pal_pkg::OP_LOCATE: begin
            r.ok = 1'b1;
            for (k = 0; k < list_len; k++) begin
               if (!r.found && list_words[k] == val) begin
                  r.found = 1'b1;
                  r.found_index = 6'(k);
               end
            end
         end
         default: ;
      endcase
      r.count     = 7'(list_len);
      r.full_res  = (list_len == pal_pkg::CAPACITY);
      r.empty_res = (list_len == 0);
      return r;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else if (r < 98) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // Random words, small values for duplicates, words already stored, extremes
   function automatic logic signed [pal_pkg::VALUE_W-1:0] pick_value();
      int r;
      logic signed [pal_pkg::VALUE_W-1:0] v;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         v = $urandom;
      end else if (r < 60) begin
         v = 32'($urandom_range(0, 15)) - 32'd8;
      end else if (r < 80 && list_len > 0) begin
         v = list_words[$urandom_range(0, list_len - 1)];
      end else if (r < 92) begin
         case ($urandom_range(0, 3))
            0: v = WORD_MIN;
            1: v = WORD_MAX;
            2: v = '0;
            default: v = '1;
         endcase
      end else begin
         v = $urandom;
      end
      return v;
   endfunction

   // Offer one request word, predict it at the edge it is taken
   task automatic send_word(input logic [pal_pkg::OP_W-1:0] op,
                            input logic [pal_pkg::POS_W-1:0] pos,
                            input logic signed [pal_pkg::VALUE_W-1:0] val);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.position  <= pos;
      req_ch.value     <= val;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      pending_results.push_back(predict_list_op(op, pos, val));
   endtask

   // Stop offering and wait until every response has come back
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // One random word; the list length drifts toward target
   task automatic send_random_item(input int target);
      int r;
      int ins_w;
      int del_w;
      logic [pal_pkg::OP_W-1:0] op;
      logic [pal_pkg::POS_W-1:0] pos;
      if (list_len < target) begin
         ins_w = 35; del_w = 10;
      end else if (list_len > target) begin
         ins_w = 10; del_w = 35;
      end else begin
         ins_w = 22; del_w = 22;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         op = reserved_ops[$urandom_range(0, 2)];
      end else if (r < 3 + ins_w) begin
         op = pal_pkg::OP_INSERT;
      end else if (r < 3 + ins_w + del_w) begin
         op = pal_pkg::OP_DELETE;
      end else begin
         case ($urandom_range(0, 2))
            0: op = pal_pkg::OP_GET;
            1: op = pal_pkg::OP_SET;
            default: op = pal_pkg::OP_LOCATE;
         endcase
      end
      if ($urandom_range(0, 99) < 12 || (op != pal_pkg::OP_INSERT && list_len == 0)) begin
         pos = 6'($urandom_range(0, 63));
      end else if (op == pal_pkg::OP_INSERT) begin
         pos = 6'($urandom_range(0, list_len));
      end else begin
         pos = 6'($urandom_range(0, list_len - 1));
      end
      send_word(op, pos, pick_value());
   endtask

   // Empty list, rejections, head/middle/tail edits, duplicates, bad codes
   task automatic test_boundaries();
      send_word(pal_pkg::OP_DELETE, 6'd0, 32'sd0);
      send_word(pal_pkg::OP_GET, 6'd0, 32'sd0);
      send_word(pal_pkg::OP_SET, 6'd0, WORD_MAX);
      send_word(pal_pkg::OP_LOCATE, 6'd0, 32'sd0);
      send_word(pal_pkg::OP_INSERT, 6'd1, 32'sd5);
      send_word(OP_RSVD5, 6'd63, WORD_MAX);
      send_word(OP_RSVD6, 6'd0, WORD_MIN);
      send_word(OP_RSVD7, 6'd42, -32'sd1);
      send_word(pal_pkg::OP_INSERT, 6'd0, WORD_MAX);
      send_word(pal_pkg::OP_INSERT, 6'd0, WORD_MIN);
      send_word(pal_pkg::OP_INSERT, 6'd2, -32'sd1);
      send_word(pal_pkg::OP_INSERT, 6'd1, 32'sd0);
      send_word(pal_pkg::OP_INSERT, 6'd3, WORD_MAX);
      send_word(pal_pkg::OP_LOCATE, 6'd0, WORD_MAX);
      send_word(pal_pkg::OP_LOCATE, 6'd63, 32'sd12345);
      send_word(pal_pkg::OP_GET, 6'd0, 32'sd0);
      send_word(pal_pkg::OP_GET, 6'd4, 32'sd0);
      send_word(pal_pkg::OP_GET, 6'd5, 32'sd0);
      send_word(pal_pkg::OP_SET, 6'd1, -32'sd1);
      send_word(pal_pkg::OP_LOCATE, 6'd0, -32'sd1);
      send_word(pal_pkg::OP_DELETE, 6'd0, 32'sd0);
      send_word(pal_pkg::OP_DELETE, 6'd3, 32'sd0);
      send_word(pal_pkg::OP_DELETE, 6'd63, 32'sd0);
      send_word(pal_pkg::OP_SET, 6'd63, WORD_MIN);
      send_word(pal_pkg::OP_GET, 6'd63, 32'sd0);
      send_word(pal_pkg::OP_INSERT, 6'd63, 32'sd7);
      send_word(pal_pkg::OP_LOCATE, 6'd0, WORD_MIN);
   endtask

   // Fill to capacity under a long response hold, then hit the full boundary
   task automatic test_fill_and_stall();
      hold_requests++;
      while (list_len < pal_pkg::CAPACITY) begin
         send_word(pal_pkg::OP_INSERT, 6'($urandom_range(0, list_len)), pick_value());
      end
      send_word(pal_pkg::OP_INSERT, 6'd0, 32'sd1);
      send_word(pal_pkg::OP_INSERT, 6'd63, 32'sd2);
      send_word(pal_pkg::OP_GET, 6'd63, 32'sd0);
      send_word(pal_pkg::OP_SET, 6'd63, WORD_MIN);
      send_word(pal_pkg::OP_LOCATE, 6'd0, WORD_MIN);
      send_word(pal_pkg::OP_DELETE, 6'd63, 32'sd0);
      send_word(pal_pkg::OP_GET, 6'd63, 32'sd0);
   endtask

   // No gaps on either side
   task automatic test_back_to_back(input int n_items);
      int target;
      no_idle = 1'b1;
      target  = $urandom_range(0, pal_pkg::CAPACITY);
      repeat (n_items) send_random_item(target);
      no_idle = 1'b0;
   endtask

   // Long random run; the target length wanders, often to empty or full
   task automatic test_random_mix(input int n_items);
      int target;
      int i;
      target = 0;
      for (i = 0; i < n_items; i++) begin
         if (i % 60 == 0) begin
            case ($urandom_range(0, 3))
               0: target = 0;
               1: target = pal_pkg::CAPACITY;
               default: target = $urandom_range(0, pal_pkg::CAPACITY);
            endcase
         end
         send_random_item(target);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         failures++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
   endtask

   // Response checker: every accepted word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            failures++;
            $display("%0t: response with nothing expected, actual count %0h", $time,
                     rsp_ch.count);
         end else begin
            exp_res = pending_results.pop_front();
            check_field("ok", exp_res.ok, rsp_ch.ok);
            check_field("read_value", exp_res.read_value, rsp_ch.read_value);
            check_field("found", exp_res.found, rsp_ch.found);
            check_field("found_index", exp_res.found_index, rsp_ch.found_index);
            check_field("count", exp_res.count, rsp_ch.count);
            check_field("full_res", exp_res.full_res, rsp_ch.full_res);
            check_field("empty_res", exp_res.empty_res, rsp_ch.empty_res);
         end
      end
   end

   // Response ready: random stalls, plus a long hold on request
   initial begin : rsp_ready_driver
      int stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            stall_left = LONG_HOLD_CYCLES;
         end else if (stall_left == 0 && !no_idle) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.operation = pal_pkg::OP_INSERT;
      req_ch.position  = '0;
      req_ch.value     = '0;
      reset            = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_boundaries();
      wait_for_drain();
      test_fill_and_stall();
      wait_for_drain();
      test_back_to_back(100);
      wait_for_drain();
      test_random_mix(1300);
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* positional_array_list_core.f */
rtl/pal_pkg.sv
rtl/pal_if.sv
rtl/pal_cell.sv
rtl/positional_array_list_core.sv
tb/positional_array_list_core_tb.sv
